// ----- design/bost_pkg.sv -----
// Shared constants and register codes for the box overlap stability tracker.
`default_nettype none

package bost_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int THR_W          = 9;
    localparam int FRAMES_W       = 8;
    localparam int FRAC_BITS      = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 9;

    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(204);
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(10);
    localparam logic [FRAMES_W-1:0] STREAK_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERLAP_THRESHOLD = 2'd0,
        REG_FRAMES_NEEDED     = 2'd1
    } t_reg_idx;

endpackage

`default_nettype wire

// ----- design/bost_if.sv -----
// Valid/ready channel interfaces for box beats, result beats and register writes.
`default_nettype none

interface bost_box_if #(
    parameter int COORD_BITS = bost_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         box_present;
    logic signed [COORD_BITS:0]   box_x;
    logic signed [COORD_BITS:0]   box_y;
    logic        [COORD_BITS-1:0] box_width;
    logic        [COORD_BITS-1:0] box_height;

    modport source (output valid, box_present, box_x, box_y, box_width, box_height,
                    input ready);
    modport sink   (input valid, box_present, box_x, box_y, box_width, box_height,
                    output ready);
endinterface

interface bost_res_if;
    logic                           valid;
    logic                           ready;
    logic                           stable;
    logic [bost_pkg::FRAMES_W-1:0]  streak_now;

    modport source (output valid, stable, streak_now, input ready);
    modport sink   (input valid, stable, streak_now, output ready);
endinterface

interface bost_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bost_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [bost_pkg::CFG_DATA_W-1:0]  wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ----- design/bost_ser_mul.sv -----
// Shift-add multiplier that consumes one multiplier bit per cycle.
`default_nettype none

module bost_ser_mul #(
    parameter int MC_W = 12,
    parameter int MP_W = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [MC_W-1:0]        i_mcand,
    input  wire logic [MP_W-1:0]        i_mplier,
    output logic                        o_done,
    output logic [MC_W+MP_W-1:0]        o_prod
);

    localparam int CNT_W = $clog2(MP_W + 1);

    logic [MC_W+MP_W-1:0] r_acc;
    logic [MC_W+MP_W-1:0] n_acc;
    logic [MC_W-1:0]      r_mcand;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MC_W:0]        sum;

    always_comb begin
        sum   = {1'b0, r_acc[MC_W+MP_W-1:MP_W]}
              + (r_acc[0] ? {1'b0, r_mcand} : {(MC_W+1){1'b0}});
        n_acc = {sum, r_acc[MP_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc   <= {{MC_W{1'b0}}, i_mplier};
                r_mcand <= i_mcand;
                r_cnt   <= CNT_W'(MP_W);
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ----- design/bost_overlap.sv -----
// Overlap engine: intersection extents, serial area products and threshold compare.
`default_nettype none

module bost_overlap #(
    parameter int COORD_BITS = bost_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [COORD_BITS:0]    i_x1,
    input  wire logic signed [COORD_BITS:0]    i_y1,
    input  wire logic        [COORD_BITS-1:0]  i_w1,
    input  wire logic        [COORD_BITS-1:0]  i_h1,
    input  wire logic signed [COORD_BITS:0]    i_x2,
    input  wire logic signed [COORD_BITS:0]    i_y2,
    input  wire logic        [COORD_BITS-1:0]  i_w2,
    input  wire logic        [COORD_BITS-1:0]  i_h2,
    input  wire logic [bost_pkg::THR_W-1:0]    i_thr,
    output logic                               o_done,
    output logic                               o_pass
);

    localparam int CW = COORD_BITS + 1;
    localparam int SW = COORD_BITS;
    localparam int EW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 3;
    localparam int PW = 2 * SW;
    localparam int UW = PW + 1;
    localparam int TW = bost_pkg::THR_W;
    localparam int QW = UW + TW;
    localparam int FB = bost_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_EDGE, S_EXT, S_MGO, S_AREA, S_UNI, S_SGO, S_SCALE
    } t_state;

    t_state r_state;

    logic signed [CW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic        [SW-1:0] r_w1, r_h1, r_w2, r_h2;
    logic        [TW-1:0] r_thr;
    logic signed [EW-1:0] r_xr, r_yr;
    logic signed [CW-1:0] r_xl, r_yl;
    logic        [SW-1:0] r_iw, r_ih;
    logic        [PW-1:0] r_inter;
    logic        [UW-1:0] r_uni;
    logic                 r_done;
    logic                 r_pass;

    logic signed [EW-1:0] ex_r1, ex_r2, ey_r1, ey_r2;
    logic signed [DW-1:0] dx, dy;
    logic        [QW-1:0] lhs;
    logic        [PW-1:0] p_inter, p_a1, p_a2;
    logic        [QW-1:0] p_scale;
    logic                 d_inter, d_a1, d_a2, d_scale;
    logic                 st_mul, st_scale;

    always_comb begin
        ex_r1 = $signed({r_x1[CW-1], r_x1}) + $signed({2'b00, r_w1});
        ex_r2 = $signed({r_x2[CW-1], r_x2}) + $signed({2'b00, r_w2});
        ey_r1 = $signed({r_y1[CW-1], r_y1}) + $signed({2'b00, r_h1});
        ey_r2 = $signed({r_y2[CW-1], r_y2}) + $signed({2'b00, r_h2});
        dx    = $signed({r_xr[EW-1], r_xr}) - $signed({{2{r_xl[CW-1]}}, r_xl});
        dy    = $signed({r_yr[EW-1], r_yr}) - $signed({{2{r_yl[CW-1]}}, r_yl});
        lhs   = {{(QW-PW-FB){1'b0}}, r_inter, {FB{1'b0}}};
    end

    assign st_mul   = (r_state == S_MGO);
    assign st_scale = (r_state == S_SGO);

    bost_ser_mul #(.MC_W(SW), .MP_W(SW)) u_mul_inter (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(st_mul),
        .i_mcand(r_iw), .i_mplier(r_ih), .o_done(d_inter), .o_prod(p_inter)
    );

    bost_ser_mul #(.MC_W(SW), .MP_W(SW)) u_mul_a1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(st_mul),
        .i_mcand(r_w1), .i_mplier(r_h1), .o_done(d_a1), .o_prod(p_a1)
    );

    bost_ser_mul #(.MC_W(SW), .MP_W(SW)) u_mul_a2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(st_mul),
        .i_mcand(r_w2), .i_mplier(r_h2), .o_done(d_a2), .o_prod(p_a2)
    );

    bost_ser_mul #(.MC_W(UW), .MP_W(TW)) u_mul_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(st_scale),
        .i_mcand(r_uni), .i_mplier(r_thr), .o_done(d_scale), .o_prod(p_scale)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x1    <= i_x1;
                        r_y1    <= i_y1;
                        r_w1    <= i_w1;
                        r_h1    <= i_h1;
                        r_x2    <= i_x2;
                        r_y2    <= i_y2;
                        r_w2    <= i_w2;
                        r_h2    <= i_h2;
                        r_thr   <= i_thr;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_xr    <= (ex_r1 < ex_r2) ? ex_r1 : ex_r2;
                    r_yr    <= (ey_r1 < ey_r2) ? ey_r1 : ey_r2;
                    r_xl    <= (r_x1 > r_x2) ? r_x1 : r_x2;
                    r_yl    <= (r_y1 > r_y2) ? r_y1 : r_y2;
                    r_state <= S_EXT;
                end
                S_EXT: begin
                    r_iw    <= (!dx[DW-1] && dx != '0) ? dx[SW-1:0] : '0;
                    r_ih    <= (!dy[DW-1] && dy != '0) ? dy[SW-1:0] : '0;
                    r_state <= S_MGO;
                end
                S_MGO: begin
                    r_state <= S_AREA;
                end
                S_AREA: begin
                    if (d_inter && d_a1 && d_a2) begin
                        r_state <= S_UNI;
                    end
                end
                S_UNI: begin
                    r_inter <= p_inter;
                    r_uni   <= {1'b0, p_a1} + {1'b0, p_a2} - {1'b0, p_inter};
                    r_state <= S_SGO;
                end
                S_SGO: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (d_scale) begin
                        r_pass  <= (r_uni == '0) ? (r_thr == '0) : (lhs >= p_scale);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_pass = r_pass;

    a_area_done_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_inter |-> (d_a1 && d_a2))
        else $error("area products finished apart");

    a_scale_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_scale |-> (r_state == S_SCALE))
        else $error("scale product finished outside its phase");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("overlap done while still working");

endmodule

`default_nettype wire

// ----- design/box_overlap_stability_tracker_top.sv -----
// Top level: handshakes, registers, stored box, streak counter and result register.
// Compare path: a box beat with a stored box yields its result beat once the serial area and
//   threshold multipliers in the overlap engine finish and the result is registered.
// Throughput: one beat at a time; such a beat holds the input until the engine is done and
//   the slot free; with a free slot, others get a result the next cycle, at a one-cycle rate.
// Reset: synchronous active-low; registers return to threshold 204, frames 10,
//   no stored box and a zero streak.
`default_nettype none

module box_overlap_stability_tracker_top #(
    parameter int COORD_BITS = bost_pkg::COORD_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    bost_box_if.sink      i_box,
    bost_res_if.source    o_res,
    bost_cfg_if.sink      i_cfg
);

    localparam int TW = bost_pkg::THR_W;
    localparam int FW = bost_pkg::FRAMES_W;

    typedef enum logic [1:0] {S_IDLE, S_BUSY, S_HOLD} t_state;

    t_state r_state, n_state;

    logic [TW-1:0]               r_thr;
    logic [FW-1:0]               r_fn;
    logic                        r_last_valid;
    logic signed [COORD_BITS:0]  r_last_x, r_last_y;
    logic [COORD_BITS-1:0]       r_last_w, r_last_h;
    logic [FW-1:0]               r_streak, n_streak;
    logic                        r_pend_stable, n_pend_stable;
    logic [FW-1:0]               r_pend_streak, n_pend_streak;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_stable, n_out_stable;
    logic [FW-1:0]               r_out_streak, n_out_streak;

    logic                        box_acc;
    logic                        eng_start, eng_done, eng_pass;
    logic                        slot_free;
    logic                        res_go, res_stable;
    logic [FW-1:0]               res_streak, inc;

    assign i_box.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign box_acc     = i_box.valid && i_box.ready;
    assign eng_start   = box_acc && i_box.box_present && r_last_valid;
    assign slot_free   = !r_out_valid || o_res.ready;

    bost_overlap #(.COORD_BITS(COORD_BITS)) u_overlap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (eng_start),
        .i_x1    (r_last_x),
        .i_y1    (r_last_y),
        .i_w1    (r_last_w),
        .i_h1    (r_last_h),
        .i_x2    (i_box.box_x),
        .i_y2    (i_box.box_y),
        .i_w2    (i_box.box_width),
        .i_h2    (i_box.box_height),
        .i_thr   (r_thr),
        .o_done  (eng_done),
        .o_pass  (eng_pass)
    );

    always_comb begin
        n_state       = r_state;
        n_streak      = r_streak;
        n_pend_stable = r_pend_stable;
        n_pend_streak = r_pend_streak;
        res_go        = 1'b0;
        res_stable    = 1'b0;
        res_streak    = '0;
        inc           = '0;

        unique case (r_state)
            S_IDLE: begin
                if (box_acc && !eng_start) begin
                    res_go     = 1'b1;
                    res_stable = i_box.box_present && (r_fn == '0);
                    n_streak   = '0;
                end else if (eng_start) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (eng_done) begin
                    if (eng_pass) begin
                        inc = (r_streak == bost_pkg::STREAK_MAX) ? r_streak
                                                                 : r_streak + FW'(1);
                    end
                    res_go = 1'b1;
                    if (inc >= r_fn) begin
                        res_stable = 1'b1;
                        res_streak = '0;
                    end else begin
                        res_streak = inc;
                    end
                    n_streak = res_streak;
                    n_state  = S_IDLE;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_stable = r_out_stable;
        n_out_streak = r_out_streak;
        if (res_go) begin
            if (slot_free) begin
                n_out_valid  = 1'b1;
                n_out_stable = res_stable;
                n_out_streak = res_streak;
            end else begin
                n_pend_stable = res_stable;
                n_pend_streak = res_streak;
                n_state       = S_HOLD;
            end
        end else if (r_state == S_HOLD && slot_free) begin
            n_out_valid  = 1'b1;
            n_out_stable = r_pend_stable;
            n_out_streak = r_pend_streak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_thr        <= bost_pkg::THR_RESET;
            r_fn         <= bost_pkg::FRAMES_RESET;
            r_last_valid <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_w     <= '0;
            r_last_h     <= '0;
            r_streak     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_streak      <= n_streak;
            r_out_valid   <= n_out_valid;
            r_out_stable  <= n_out_stable;
            r_out_streak  <= n_out_streak;
            r_pend_stable <= n_pend_stable;
            r_pend_streak <= n_pend_streak;
            if (box_acc) begin
                r_last_valid <= i_box.box_present;
                if (i_box.box_present) begin
                    r_last_x <= i_box.box_x;
                    r_last_y <= i_box.box_y;
                    r_last_w <= i_box.box_width;
                    r_last_h <= i_box.box_height;
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.reg_index)
                    bost_pkg::REG_OVERLAP_THRESHOLD: r_thr <= i_cfg.wr_data[TW-1:0];
                    bost_pkg::REG_FRAMES_NEEDED:     r_fn  <= i_cfg.wr_data[FW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.stable     = r_out_stable;
    assign o_res.streak_now = r_out_streak;

    a_stable_clears_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stable) |-> (r_out_streak == '0))
        else $error("stable beat with nonzero streak");

    a_nobox_forgets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (box_acc && !i_box.box_present) |=> (!r_last_valid && r_streak == '0))
        else $error("no-box beat left box or streak");

    a_engine_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |-> (r_state == S_BUSY))
        else $error("overlap result outside busy state");

endmodule

`default_nettype wire
